### design/drrip_pkg.sv
package drrip_pkg;

	localparam int NUM_SETS     = 2048;
	localparam int NUM_WAYS     = 16;
	localparam int LEADER_COUNT = 64;

	localparam int SET_W       = $clog2(NUM_SETS);
	localparam int WAY_W       = $clog2(NUM_WAYS);
	localparam int RRPV_ROW_W  = 2 * NUM_WAYS;
	localparam int ADDR_W      = 64;
	localparam int SLICE_W     = 16;
	localparam int SLICES      = ADDR_W / SLICE_W;
	localparam int SLICE_IDX_W = $clog2(SLICES);

	localparam logic [SET_W-1:0]       LAST_SET   = SET_W'(NUM_SETS - 1);
	localparam logic [SET_W-1:0]       SR_END     = SET_W'(LEADER_COUNT);
	localparam logic [SET_W-1:0]       BR_START   = SET_W'(NUM_SETS / 2);
	localparam logic [SET_W:0]         BR_END     = (SET_W + 1)'(NUM_SETS / 2 + LEADER_COUNT);
	localparam logic [SLICE_IDX_W-1:0] LAST_SLICE = SLICE_IDX_W'(SLICES - 1);
	localparam logic [WAY_W:0]         WAY_LIMIT  = (WAY_W + 1)'(NUM_WAYS);

	localparam logic [1:0] RRPV_MAX  = 2'd3;
	localparam logic [1:0] RRPV_LONG = 2'd2;
	localparam logic [1:0] CONF_MAX  = 2'd3;
	localparam logic [1:0] CONF_SEEN = 2'd2;
	localparam logic [9:0] DUEL_MAX  = 10'd1023;
	localparam logic [9:0] DUEL_MID  = 10'd512;

	localparam logic REQ_VICTIM = 1'b0;
	localparam logic REQ_UPDATE = 1'b1;

	typedef struct packed {
		logic        req_type;
		logic [10:0] set_index;
		logic [3:0]  way_index;
		logic [15:0] valid_mask;
		logic [63:0] address;
		logic        hit;
		logic [4:0]  random_draw;
	} req_t;

	typedef struct packed {
		logic [3:0] victim_way;
		logic       stream_detected;
		logic [9:0] selector_value;
	} rsp_t;

	typedef struct packed {
		logic [1:0]            conf;
		logic [ADDR_W-1:0]     hist_delta;
		logic [ADDR_W-1:0]     hist_addr;
		logic [RRPV_ROW_W-1:0] rrpv;
	} row_t;

	localparam int ROW_W = $bits(row_t);

	typedef struct packed {
		logic                   step;
		logic                   first;
		logic [SLICE_IDX_W-1:0] slice;
	} delta_ctl_t;

	typedef struct packed {
		logic [ADDR_W-1:0] delta;
		logic              eq;
		logic              nz;
	} delta_res_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_DELTA,
		ST_WRITE
	} state_t;

endpackage

### design/drrip_row_mem.sv
module drrip_row_mem #(
	parameter int DEPTH = 2048,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### design/drrip_delta_unit.sv
module drrip_delta_unit (
	input  logic                                clk,
	input  drrip_pkg::delta_ctl_t               ctl,
	input  logic [drrip_pkg::ADDR_W-1:0]        addr,
	input  logic [drrip_pkg::ADDR_W-1:0]        hist_addr,
	input  logic [drrip_pkg::ADDR_W-1:0]        hist_delta,
	output drrip_pkg::delta_res_t               res
);

	logic [drrip_pkg::ADDR_W-1:0]  delta_q;
	logic                          carry_q;
	logic                          eq_q;
	logic                          nz_q;
	logic [drrip_pkg::SLICE_W-1:0] a_sl;
	logic [drrip_pkg::SLICE_W-1:0] l_sl;
	logic [drrip_pkg::SLICE_W-1:0] d_sl;
	logic [drrip_pkg::SLICE_W:0]   sum;
	logic                          cin;
	logic                          eq_in;
	logic                          nz_in;

	// one 16-bit subtract/compare slice per step, low slice first
	always_comb begin
		a_sl  = addr[ctl.slice*drrip_pkg::SLICE_W +: drrip_pkg::SLICE_W];
		l_sl  = hist_addr[ctl.slice*drrip_pkg::SLICE_W +: drrip_pkg::SLICE_W];
		d_sl  = hist_delta[ctl.slice*drrip_pkg::SLICE_W +: drrip_pkg::SLICE_W];
		cin   = ctl.first ? 1'b1 : carry_q;
		eq_in = ctl.first ? 1'b1 : eq_q;
		nz_in = ctl.first ? 1'b0 : nz_q;
		sum   = {1'b0, a_sl} + {1'b0, ~l_sl} + (drrip_pkg::SLICE_W + 1)'(cin);
	end

	always_ff @(posedge clk) begin
		if (ctl.step) begin
			carry_q <= sum[drrip_pkg::SLICE_W];
			eq_q    <= eq_in && (sum[drrip_pkg::SLICE_W-1:0] == d_sl);
			nz_q    <= nz_in || (sum[drrip_pkg::SLICE_W-1:0] != '0);
			delta_q[ctl.slice*drrip_pkg::SLICE_W +: drrip_pkg::SLICE_W]
				<= sum[drrip_pkg::SLICE_W-1:0];
		end
	end

	assign res.delta = delta_q;
	assign res.eq    = eq_q;
	assign res.nz    = nz_q;

endmodule

### design/drrip_replacement_with_stream_bypass_top.sv
// Channel  Dir  Handshake              Payload
// req      in   req_valid / req_stall  drrip_pkg::req_t
// rsp      out  rsp_valid / rsp_stall  drrip_pkg::rsp_t
//
// Victim request steps: accept, row read, age and write back.
// Update: the 64-bit stride delta goes through one 16-bit
// subtract/compare slice in 4 steps.
// After reset a clearing pass zeroes the set memory, req_stall high.
// A stalled result holds in the output register; the next beat is still
// accepted and waits in write-back until the output register frees up.
module drrip_replacement_with_stream_bypass_top (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  drrip_pkg::req_t req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output drrip_pkg::rsp_t rsp
);

	drrip_pkg::state_t                     state_q, state_d;
	logic [drrip_pkg::SET_W-1:0]           clr_q;
	logic [drrip_pkg::SLICE_IDX_W-1:0]     cnt_q;
	logic [9:0]                            duel_q;
	logic                                  rsp_valid_q;
	drrip_pkg::rsp_t                       rsp_q;
	drrip_pkg::req_t                       item_q;

	logic [drrip_pkg::SET_W-1:0]           set_q;
	logic                                  accept;
	logic                                  rsp_free;
	logic                                  commit;

	logic                                  mem_we;
	logic [drrip_pkg::SET_W-1:0]           mem_waddr;
	drrip_pkg::row_t                       mem_wdata;
	drrip_pkg::row_t                       row_rd;
	logic [drrip_pkg::ROW_W-1:0]           row_rd_bits;

	drrip_pkg::delta_ctl_t                 dctl;
	drrip_pkg::delta_res_t                 dres;

	logic [drrip_pkg::NUM_WAYS-1:0]        hi_bits;
	logic [drrip_pkg::NUM_WAYS-1:0]        lo_bits;
	logic [1:0]                            top;
	logic [1:0]                            add;
	logic [drrip_pkg::RRPV_ROW_W-1:0]      aged;
	logic                                  inv_found;
	logic [3:0]                            inv_way;
	logic                                  max_found;
	logic [3:0]                            max_way;

	logic                                  has_hist;
	logic [1:0]                            conf_new;
	logic                                  seen;
	logic                                  lead_sr;
	logic                                  lead_br;
	logic [1:0]                            brrip;
	logic [1:0]                            ins;
	logic [1:0]                            way_val;
	logic                                  way_ok;
	logic [drrip_pkg::RRPV_ROW_W-1:0]      upd_rrpv;
	logic [9:0]                            duel_d;
	drrip_pkg::row_t                       row_new;
	drrip_pkg::rsp_t                       rsp_d;

	assign set_q       = item_q.set_index[drrip_pkg::SET_W-1:0];
	assign accept      = req_valid && !req_stall;
	assign rsp_free    = !rsp_valid_q || !rsp_stall;
	assign commit      = (state_q == drrip_pkg::ST_WRITE) && rsp_free;
	assign row_rd      = drrip_pkg::row_t'(row_rd_bits);

	drrip_row_mem #(
		.DEPTH(drrip_pkg::NUM_SETS),
		.WIDTH(drrip_pkg::ROW_W)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(set_q),
		.rdata(row_rd_bits)
	);

	drrip_delta_unit u_delta (
		.clk       (clk),
		.ctl       (dctl),
		.addr      (item_q.address),
		.hist_addr (row_rd.hist_addr),
		.hist_delta(row_rd.hist_delta),
		.res       (dres)
	);

	// victim search: max of 2-bit values from the high and low bit planes, then ageing and the first invalid or max way
	always_comb begin
		for (int w = 0; w < drrip_pkg::NUM_WAYS; w++) begin
			hi_bits[w] = row_rd.rrpv[2*w+1];
			lo_bits[w] = row_rd.rrpv[2*w];
		end
		top[1] = |hi_bits;
		top[0] = top[1] ? |(hi_bits & lo_bits) : |lo_bits;
		add    = drrip_pkg::RRPV_MAX - top;
		for (int w = 0; w < drrip_pkg::NUM_WAYS; w++) begin
			aged[2*w +: 2] = row_rd.rrpv[2*w +: 2] + add;
		end
		inv_found = 1'b0;
		inv_way   = '0;
		max_found = 1'b0;
		max_way   = '0;
		for (int w = 0; w < drrip_pkg::NUM_WAYS; w++) begin
			if (!inv_found && !item_q.valid_mask[w]) begin
				inv_found = 1'b1;
				inv_way   = 4'(w);
			end
			if (!max_found && aged[2*w +: 2] == drrip_pkg::RRPV_MAX) begin
				max_found = 1'b1;
				max_way   = 4'(w);
			end
		end
	end

	// stream detector, insertion choice and duel counter
	always_comb begin
		has_hist = |row_rd.hist_addr;
		conf_new = row_rd.conf;
		if (has_hist) begin
			if (dres.eq && dres.nz) begin
				if (row_rd.conf != drrip_pkg::CONF_MAX) begin
					conf_new = row_rd.conf + 2'd1;
				end
			end else if (row_rd.conf != 2'd0) begin
				conf_new = row_rd.conf - 2'd1;
			end
		end
		seen    = has_hist && (conf_new >= drrip_pkg::CONF_SEEN);
		lead_sr = set_q < drrip_pkg::SR_END;
		lead_br = (set_q >= drrip_pkg::BR_START) && ({1'b0, set_q} < drrip_pkg::BR_END);
		brrip   = (item_q.random_draw == '0) ? drrip_pkg::RRPV_LONG : drrip_pkg::RRPV_MAX;
		if (seen) begin
			ins = drrip_pkg::RRPV_MAX;
		end else if (lead_sr) begin
			ins = drrip_pkg::RRPV_LONG;
		end else if (lead_br) begin
			ins = brrip;
		end else begin
			ins = (duel_q >= drrip_pkg::DUEL_MID) ? drrip_pkg::RRPV_LONG : brrip;
		end
		way_val = item_q.hit ? 2'd0 : ins;
		way_ok  = {1'b0, item_q.way_index[drrip_pkg::WAY_W-1:0]} < drrip_pkg::WAY_LIMIT;
		for (int w = 0; w < drrip_pkg::NUM_WAYS; w++) begin
			upd_rrpv[2*w +: 2] = (way_ok && item_q.way_index == 4'(w)) ? way_val
				: row_rd.rrpv[2*w +: 2];
		end
		duel_d = duel_q;
		if (item_q.hit) begin
			if (lead_sr && duel_q != drrip_pkg::DUEL_MAX) begin
				duel_d = duel_q + 10'd1;
			end
			if (lead_br && duel_q != 10'd0) begin
				duel_d = duel_q - 10'd1;
			end
		end
	end

	always_comb begin
		row_new = row_rd;
		rsp_d   = '0;
		if (item_q.req_type == drrip_pkg::REQ_UPDATE) begin
			row_new.conf       = conf_new;
			row_new.hist_delta = dres.delta;
			row_new.hist_addr  = item_q.address;
			row_new.rrpv       = upd_rrpv;
			rsp_d.stream_detected = seen;
			rsp_d.selector_value  = duel_d;
		end else begin
			if (inv_found) begin
				rsp_d.victim_way = inv_way;
			end else begin
				row_new.rrpv     = aged;
				rsp_d.victim_way = max_way;
			end
			rsp_d.selector_value = duel_q;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			drrip_pkg::ST_CLEAR: begin
				if (clr_q == drrip_pkg::LAST_SET) begin
					state_d = drrip_pkg::ST_IDLE;
				end
			end
			drrip_pkg::ST_IDLE: begin
				if (req_valid) begin
					state_d = drrip_pkg::ST_READ;
				end
			end
			drrip_pkg::ST_READ: begin
				state_d = (item_q.req_type == drrip_pkg::REQ_UPDATE) ? drrip_pkg::ST_DELTA
					: drrip_pkg::ST_WRITE;
			end
			drrip_pkg::ST_DELTA: begin
				if (cnt_q == drrip_pkg::LAST_SLICE) begin
					state_d = drrip_pkg::ST_WRITE;
				end
			end
			drrip_pkg::ST_WRITE: begin
				if (rsp_free) begin
					state_d = drrip_pkg::ST_IDLE;
				end
			end
			default: state_d = drrip_pkg::ST_CLEAR;
		endcase
	end

	always_comb begin
		req_stall  = 1'b1;
		mem_we     = 1'b0;
		mem_waddr  = set_q;
		mem_wdata  = row_new;
		dctl.step  = 1'b0;
		dctl.first = (cnt_q == '0);
		dctl.slice = cnt_q;
		case (state_q)
			drrip_pkg::ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			drrip_pkg::ST_IDLE: begin
				req_stall = 1'b0;
			end
			drrip_pkg::ST_DELTA: begin
				dctl.step = 1'b1;
			end
			drrip_pkg::ST_WRITE: begin
				mem_we = rsp_free;
			end
			default: begin
				req_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= drrip_pkg::ST_CLEAR;
			clr_q       <= '0;
			cnt_q       <= '0;
			duel_q      <= drrip_pkg::DUEL_MID;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == drrip_pkg::ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == drrip_pkg::ST_DELTA) begin
				cnt_q <= (cnt_q == drrip_pkg::LAST_SLICE) ? '0 : cnt_q + 1'b1;
			end
			if (commit) begin
				rsp_valid_q <= 1'b1;
				if (item_q.req_type == drrip_pkg::REQ_UPDATE) begin
					duel_q <= duel_d;
				end
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= req;
		end
		if (commit) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

### design/drrip_checker.sv
module drrip_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            req_valid,
	input logic            req_stall,
	input drrip_pkg::req_t req,
	input logic            rsp_valid,
	input logic            rsp_stall,
	input drrip_pkg::rsp_t rsp
);

	// a stalled result beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled result changed");

	// the block is busy in the cycle after it takes a beat
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("beat accepted back to back");

	// a new result only comes out of write-back, never from idle
	a_rsp_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_stall))
		else $error("result appeared while idle");

	// update results carry no victim way
	a_stream_no_victim: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.stream_detected |-> rsp.victim_way == '0)
		else $error("stream flag on a victim result");

endmodule

bind drrip_replacement_with_stream_bypass_top drrip_checker u_chk (.*);
